### hw/rtl/ctv_pkg.sv
package ctv_pkg;

	localparam int CTV_VW = 32;
	localparam int CTV_FB = 16;
	localparam int CTV_CFG_IDX_W = 2;

	localparam logic [CTV_CFG_IDX_W-1:0] CFG_REFERENCE_VOLUME = 2'd0;
	localparam logic [CTV_CFG_IDX_W-1:0] CFG_GROWTH_DURATION_SET = 2'd1;
	localparam logic [CTV_CFG_IDX_W-1:0] CFG_GROWTH_DURATION = 2'd2;
	localparam logic [CTV_CFG_IDX_W-1:0] CFG_T1_ADAPTATION_DURATION = 2'd3;

	typedef logic [CTV_VW-1:0] ctv_val_t;

	typedef struct packed {
		ctv_val_t age_now;
		ctv_val_t g1_duration;
		logic     is_apoptotic;
		ctv_val_t age_at_apoptosis;
		ctv_val_t time_apoptotic;
		ctv_val_t apoptosis_duration;
		logic     ready_to_divide;
		logic     has_t1_record;
		ctv_val_t t1_elapsed;
		ctv_val_t t1_volume;
	} ctv_in_t;

	typedef struct packed {
		ctv_val_t target_volume;
		logic     zero_duration_flag;
	} ctv_out_t;

	// travels with the growth division
	typedef struct packed {
		logic     apo;
		logic     ready;
		logic     grow;
		ctv_val_t t_apo;
		ctv_val_t d_apo;
		logic     has_t1;
		ctv_val_t s;
		ctv_val_t v;
	} ctv_side_a_t;

	// travels with the apoptosis division
	typedef struct packed {
		logic     apo;
		logic     zero_d;
		logic     clamp;
		ctv_val_t base;
		ctv_val_t c1n;
	} ctv_side_b_t;

	// travels with the T1 division
	typedef struct packed {
		logic     t1_use;
		logic     r_ge_v;
		ctv_val_t v;
	} ctv_side_c_t;

endpackage

### hw/rtl/cell_target_volume_rule_unit.sv
// Channel   Ports                          Transfer
// -------   -----------------------------  --------------------------------------
// cell in   start, busy, cell_info         edge with start high and busy low
// result    done, result                   done high for one cycle, always taken
// config    cfg_we, cfg_idx, cfg_wdata     edge with cfg_we high
//
// One cell enters per cycle; busy is never raised. The result of a cell passes
// the capture register, two bit-serial divider pipelines in series (the growth
// fraction, then the apoptosis shrink; the T1 division runs beside the second
// one), then the candidate register and the result register.
// Reset clears all valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
module cell_target_volume_rule_unit
	import ctv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  ctv_in_t                  cell_info,
	output logic                     done,
	output ctv_out_t                 result,
	input  logic                     cfg_we,
	input  logic [CTV_CFG_IDX_W-1:0] cfg_idx,
	input  ctv_val_t                 cfg_wdata
);

	localparam int LAT = 2 * CTV_VW + 7;

	// configuration registers
	ctv_val_t ref_q;
	logic     gset_q;
	ctv_val_t gdur_q;
	ctv_val_t t1dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q   <= CTV_VW'(1) << CTV_FB;
			gset_q  <= 1'b0;
			gdur_q  <= '0;
			t1dur_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_REFERENCE_VOLUME:       ref_q   <= cfg_wdata;
				CFG_GROWTH_DURATION_SET:    gset_q  <= cfg_wdata[0];
				CFG_GROWTH_DURATION:        gdur_q  <= cfg_wdata;
				CFG_T1_ADAPTATION_DURATION: t1dur_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: capture the cell
	logic    vld_s1;
	ctv_in_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= cell_info;
	end

	// pick growth duration and the age that feeds the growth fraction
	ctv_val_t    g_dur;
	ctv_val_t    age_sel;
	ctv_side_a_t side_a_in;

	assign g_dur   = gset_q ? gdur_q : in_s1.g1_duration;
	assign age_sel = in_s1.is_apoptotic ? in_s1.age_at_apoptosis : in_s1.age_now;

	always_comb begin
		side_a_in.apo    = in_s1.is_apoptotic;
		side_a_in.ready  = in_s1.ready_to_divide;
		side_a_in.grow   = age_sel < g_dur;
		side_a_in.t_apo  = in_s1.time_apoptotic;
		side_a_in.d_apo  = in_s1.apoptosis_duration;
		side_a_in.has_t1 = in_s1.has_t1_record;
		side_a_in.s      = in_s1.t1_elapsed;
		side_a_in.v      = in_s1.t1_volume;
	end

	// growth division: R*age/G
	logic        vld_a;
	ctv_val_t    quot_a;
	ctv_side_a_t side_a;

	ctv_muldiv #(.W(CTV_VW), .QB(CTV_VW), .SB($bits(ctv_side_a_t))) u_div_grow (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.a        (ref_q),
		.b        (age_sel),
		.c        (g_dur),
		.side     (side_a_in),
		.out_valid(vld_a),
		.quot     (quot_a),
		.side_out (side_a)
	);

	// stage 2: growth fraction, apoptosis base, T1 setup
	ctv_val_t gfrac;
	assign gfrac = (ref_q >> 1) + (quot_a >> 1) + CTV_VW'(ref_q[0] & quot_a[0]);

	logic        vld_s2;
	ctv_side_b_t sb_s2;
	ctv_side_c_t sc_s2;
	ctv_val_t    t_apo_s2;
	ctv_val_t    d_apo_s2;
	ctv_val_t    s_s2;
	ctv_val_t    diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_a;
		end
	end

	always_ff @(posedge clk) begin
		sb_s2.apo    <= side_a.apo;
		sb_s2.zero_d <= side_a.d_apo == '0;
		sb_s2.clamp  <= (side_a.t_apo >> 1) >= side_a.d_apo;
		sb_s2.base   <= side_a.grow ? gfrac : ref_q;
		sb_s2.c1n    <= side_a.grow ? gfrac : (side_a.ready ? (ref_q >> 1) : ref_q);
		sc_s2.t1_use <= side_a.has_t1 && (t1dur_q != '0) && (side_a.s < t1dur_q);
		sc_s2.r_ge_v <= ref_q >= side_a.v;
		sc_s2.v      <= side_a.v;
		t_apo_s2     <= side_a.t_apo;
		d_apo_s2     <= side_a.d_apo;
		s_s2         <= side_a.s;
		diff_s2      <= (ref_q >= side_a.v) ? ref_q - side_a.v : side_a.v - ref_q;
	end

	// apoptosis division: base*t_apo/D, quotient below 2*base when not clamped
	logic          vld_b;
	logic [CTV_VW:0] quot_b;
	ctv_side_b_t   side_b;

	ctv_muldiv #(.W(CTV_VW), .QB(CTV_VW + 1), .SB($bits(ctv_side_b_t))) u_div_apo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.a        (sb_s2.base),
		.b        (t_apo_s2),
		.c        (d_apo_s2),
		.side     (sb_s2),
		.out_valid(vld_b),
		.quot     (quot_b),
		.side_out (side_b)
	);

	// T1 division: |R-v|*s/T, same depth as the apoptosis one
	logic          vld_c;
	logic [CTV_VW:0] quot_c;
	ctv_side_c_t   side_c;

	ctv_muldiv #(.W(CTV_VW), .QB(CTV_VW + 1), .SB($bits(ctv_side_c_t))) u_div_t1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.a        (diff_s2),
		.b        (s_s2),
		.c        (t1dur_q),
		.side     (sc_s2),
		.out_valid(vld_c),
		.quot     (quot_c),
		.side_out (side_c)
	);

	// stage 3: both candidates
	logic     vld_s3;
	ctv_val_t c1_s3;
	ctv_val_t c2_s3;
	logic     flag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_b;
		end
	end

	always_ff @(posedge clk) begin
		if (side_b.apo) begin
			c1_s3 <= (side_b.zero_d || side_b.clamp) ? '0 : side_b.base - quot_b[CTV_VW:1];
		end else begin
			c1_s3 <= side_b.c1n;
		end
		if (side_c.t1_use) begin
			c2_s3 <= side_c.r_ge_v ? side_c.v + quot_c[CTV_VW-1:0]
			                       : side_c.v - quot_c[CTV_VW-1:0];
		end else begin
			c2_s3 <= ref_q;
		end
		flag_s3 <= side_b.apo && side_b.zero_d;
	end

	// stage 4: keep the candidate farther from the reference, tie to T1
	ctv_val_t dist1;
	ctv_val_t dist2;

	assign dist1 = (c1_s3 >= ref_q) ? c1_s3 - ref_q : ref_q - c1_s3;
	assign dist2 = (c2_s3 >= ref_q) ? c2_s3 - ref_q : ref_q - c2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		result.target_volume      <= (dist1 > dist2) ? c1_s3 : c2_s3;
		result.zero_duration_flag <= flag_s3;
	end

	// every accepted cell comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after fixed latency");

	// the two parallel dividers stay in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_b == vld_c)
		else $error("apoptosis and T1 dividers out of step");

	// a zero apoptosis duration in an apoptotic cell forces the first candidate to zero
	a_zero_c1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && flag_s3) |-> (c1_s3 == '0))
		else $error("zero duration without zero candidate");

	// no result strobe without a cell in the last stage
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s3))
		else $error("result strobe without source");

endmodule

### hw/rtl/ctv_muldiv.sv
// Pipelined floor(a*b/c): one multiply stage, then one quotient bit per stage.
// Valid only when the quotient fits in QB bits.
module ctv_muldiv #(
	parameter int W  = 32,
	parameter int QB = 32,
	parameter int SB = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [W-1:0]  a,
	input  logic [W-1:0]  b,
	input  logic [W-1:0]  c,
	input  logic [SB-1:0] side,
	output logic          out_valid,
	output logic [QB-1:0] quot,
	output logic [SB-1:0] side_out
);

	logic [2*W-1:0] prod;
	logic           vld_s  [0:QB];
	logic [W-1:0]   rem_s  [0:QB-1];
	logic [QB-1:0]  low_s  [0:QB];
	logic [W-1:0]   den_s  [0:QB-1];
	logic [SB-1:0]  side_s [0:QB];

	assign prod = (2*W)'(a) * (2*W)'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= W'(prod >> QB);
		low_s[0]  <= prod[QB-1:0];
		den_s[0]  <= c;
		side_s[0] <= side;
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [W:0] trial;
		logic       ge;

		assign trial = {rem_s[k], low_s[k][QB-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			low_s[k+1]  <= {low_s[k][QB-2:0], ge};
			side_s[k+1] <= side_s[k];
		end

		// the last step keeps only its quotient bit
		if (k < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? W'(trial - {1'b0, den_s[k]}) : W'(trial);
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign out_valid = vld_s[QB];
	assign quot      = low_s[QB];
	assign side_out  = side_s[QB];

endmodule
